// ----- rtl/fifo_lock_queue_manager_macros.svh -----
// Assertion macros for the FIFO lock queue manager checker.
// Used by the checker only; no other dependencies.
`ifndef FIFO_LOCK_QUEUE_MANAGER_MACROS_SVH
`define FIFO_LOCK_QUEUE_MANAGER_MACROS_SVH

// same-cycle implication
`define FLQM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flqm assertion failed");

// next-cycle implication
`define FLQM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flqm assertion failed");

`endif

// ----- rtl/flqm_pkg.sv -----
// Shared types, codes and defaults of the FIFO lock queue manager.
// No dependencies.
`timescale 1ns / 1ps
package flqm_pkg;

    localparam int DEF_MUTEX_SLOTS = 16;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int ID_W            = 16;

    localparam logic [1:0] FN_ACQUIRE = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_REMOVE  = 2'd2;
    localparam logic [1:0] FN_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_PERM = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] RD_POS  = 2'd0;
    localparam logic [1:0] RD_POS1 = 2'd1;
    localparam logic [1:0] RD_HEAD = 2'd2;

    localparam logic EP_WHO  = 1'b0;
    localparam logic EP_HEAD = 1'b1;

    localparam logic [1:0] ANS_ZERO    = 2'd0;
    localparam logic [1:0] ANS_MATCH   = 2'd1;
    localparam logic [1:0] ANS_REMOVED = 2'd2;

    typedef struct packed {
        logic [1:0]      func;
        logic [ID_W-1:0] lock_id;
        logic [ID_W-1:0] requester;
        logic            wake_req;
        logic            kill_flag;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0] reply_endpoint;
        logic [1:0]      reply_status;
        logic            is_message;
        logic            answer;
        logic            last;
    } t_result;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       alloc;
        logic       append;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_shift;
        logic       pos_inc;
        logic       dec_fill;
        logic       cur_next;
        logic       set_removed;
        logic       emit;
        logic       ep_sel;
        logic [1:0] status;
        logic       msg;
        logic [1:0] ans_sel;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       scan_done;
        logic       found;
        logic       free_ok;
        logic       fill_zero;
        logic       fill_full;
        logic       pos1_lt_fill;
        logic       head_match;
        logic       used_cur;
        logic       cur_last;
        logic       pos_zero;
        logic       pop_head;
        logic [1:0] func;
        logic       wake;
        logic       kill;
    } t_stat;

endpackage

// ----- rtl/fifo_lock_queue_manager.sv -----
// Top level of the FIFO lock queue manager: controller plus datapath.
// Depends on flqm_pkg, flqm_ctrl and flqm_dp.
// One request at a time: busy is high from the transfer until the work is done.
// Every request scans all MUTEX_SLOTS slots (remove scans the stored entries of
// each used slot instead), then shifts each entry behind a released or removed
// waiter down one place, reading it in S_SH and writing it in S_SH_WR, since the
// queue memory has a single read and a single write port. Results appear on
// o_result with o_strobe for one cycle each, back to back when a request gives
// two; the receiver cannot stall them, so they must be taken at once.
`timescale 1ns / 1ps
module fifo_lock_queue_manager
    import flqm_pkg::*;
#(
    parameter int MUTEX_SLOTS = DEF_MUTEX_SLOTS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);
    t_cmd  cmd;
    t_stat stat;

    flqm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    flqm_dp #(
        .MUTEX_SLOTS (MUTEX_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ----- rtl/flqm_dp.sv -----
// Datapath: slot table, fill counts, waiter memory, scan counters, result register.
// Depends on flqm_pkg.
`timescale 1ns / 1ps
module flqm_dp
    import flqm_pkg::*;
#(
    parameter int MUTEX_SLOTS = DEF_MUTEX_SLOTS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    output logic    o_strobe,
    output t_result o_result
);
    localparam int SW = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int MD = MUTEX_SLOTS * QUEUE_DEPTH;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;

    logic [ID_W-1:0] r_key  [MUTEX_SLOTS];
    logic            r_used [MUTEX_SLOTS];
    logic [FW-1:0]   r_fill [MUTEX_SLOTS];
    logic [ID_W-1:0] r_mem  [MD];

    t_item           r_req;
    logic [SW-1:0]   r_scan;
    logic [SW-1:0]   r_cur;
    logic [SW-1:0]   r_free;
    logic [FW-1:0]   r_pos;
    logic            r_found;
    logic            r_free_ok;
    logic            r_removed;
    logic            r_pop_head;
    logic [ID_W-1:0] r_rdata;
    logic            r_strobe;
    t_result         r_result;

    logic [FW-1:0]   cur_fill;
    logic [AW-1:0]   base;
    logic [AW-1:0]   raddr;
    logic [AW-1:0]   waddr;
    logic [ID_W-1:0] wdata;
    logic            wen;
    logic            hit;
    logic            ans;
    logic [FW:0]     pos1;

    assign cur_fill = r_fill[r_cur];
    assign base     = AW'(r_cur) * AW'(QUEUE_DEPTH);
    assign pos1     = {1'b0, r_pos} + (FW+1)'(1);
    assign hit      = r_used[r_scan] && (r_key[r_scan] == r_req.lock_id);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_POS:  raddr = base + AW'(r_pos);
            RD_POS1: raddr = base + AW'(pos1);
            default: raddr = base;
        endcase
    end

    assign wen   = i_cmd.append | i_cmd.wr_shift;
    assign waddr = i_cmd.append ? base + AW'(cur_fill) : base + AW'(r_pos);
    assign wdata = i_cmd.append ? r_req.requester : r_rdata;

    always_comb begin
        case (i_cmd.ans_sel)
            ANS_MATCH:   ans = (r_rdata == r_req.requester);
            ANS_REMOVED: ans = r_removed;
            default:     ans = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MUTEX_SLOTS; i++) begin
                r_used[i] <= 1'b0;
                r_fill[i] <= '0;
            end
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.alloc) begin
                r_used[r_free] <= 1'b1;
                r_fill[r_free] <= '0;
            end
            if (i_cmd.append) begin
                r_fill[r_cur] <= cur_fill + FW'(1);
            end
            if (i_cmd.dec_fill) begin
                r_fill[r_cur] <= cur_fill - FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= i_item;
            r_scan     <= '0;
            r_cur      <= '0;
            r_pos      <= '0;
            r_found    <= 1'b0;
            r_free_ok  <= 1'b0;
            r_removed  <= 1'b0;
            r_pop_head <= 1'b0;
        end
        if (i_cmd.scan) begin
            r_scan <= r_scan + SW'(1);
            if (hit && !r_found) begin
                r_found <= 1'b1;
                r_cur   <= r_scan;
            end
            if (!r_used[r_scan] && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free    <= r_scan;
            end
        end
        if (i_cmd.alloc) begin
            r_key[r_free] <= r_req.lock_id;
            r_cur         <= r_free;
        end
        if (i_cmd.wr_shift || i_cmd.pos_inc) begin
            r_pos <= r_pos + FW'(1);
        end
        if (i_cmd.cur_next) begin
            r_cur <= r_cur + SW'(1);
            r_pos <= '0;
        end
        if (i_cmd.set_removed) begin
            r_removed  <= 1'b1;
            r_pop_head <= (r_pos == '0);
        end
        if (i_cmd.emit) begin
            r_result.reply_endpoint <= (i_cmd.ep_sel == EP_HEAD) ? r_rdata : r_req.requester;
            r_result.reply_status   <= i_cmd.status;
            r_result.is_message     <= i_cmd.msg;
            r_result.answer         <= ans;
            r_result.last           <= i_cmd.last;
        end
    end

    assign o_stat.scan_done    = (r_scan == SW'(MUTEX_SLOTS - 1));
    assign o_stat.found        = r_found;
    assign o_stat.free_ok      = r_free_ok;
    assign o_stat.fill_zero    = (cur_fill == '0);
    assign o_stat.fill_full    = (cur_fill >= FW'(QUEUE_DEPTH));
    assign o_stat.pos1_lt_fill = (pos1 < {1'b0, cur_fill});
    assign o_stat.head_match   = (r_rdata == r_req.requester);
    assign o_stat.used_cur     = r_used[r_cur];
    assign o_stat.cur_last     = (r_cur == SW'(MUTEX_SLOTS - 1));
    assign o_stat.pos_zero     = (r_pos == '0);
    assign o_stat.pop_head     = r_pop_head;
    assign o_stat.func         = r_req.func;
    assign o_stat.wake         = r_req.wake_req;
    assign o_stat.kill         = r_req.kill_flag;

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/flqm_ctrl.sv -----
// Controller: sequences slot scans, queue reads, shifts and result transfers.
// Depends on flqm_pkg.
`timescale 1ns / 1ps
module flqm_ctrl
    import flqm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  [1:0] i_func,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOOK    = 4'd1;
    localparam logic [3:0] S_DEC     = 4'd2;
    localparam logic [3:0] S_ACQ     = 4'd3;
    localparam logic [3:0] S_REL_CHK = 4'd4;
    localparam logic [3:0] S_Q_CHK   = 4'd5;
    localparam logic [3:0] S_SH      = 4'd6;
    localparam logic [3:0] S_SH_WR   = 4'd7;
    localparam logic [3:0] S_POST    = 4'd8;
    localparam logic [3:0] S_GRANT   = 4'd9;
    localparam logic [3:0] S_RM_SLOT = 4'd10;
    localparam logic [3:0] S_RM_CHK  = 4'd11;
    localparam logic [3:0] S_RM_DONE = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = (i_func == FN_REMOVE) ? S_RM_SLOT : S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                unique case (i_stat.func)
                    FN_ACQUIRE: begin
                        if (i_stat.found) begin
                            n_state = S_ACQ;
                        end else if (i_stat.free_ok) begin
                            cmd.alloc = 1'b1;
                            n_state   = S_ACQ;
                        end else begin
                            cmd.emit   = 1'b1;
                            cmd.status = ST_FULL;
                            cmd.msg    = 1'b1;
                            cmd.last   = 1'b1;
                        end
                    end
                    FN_RELEASE: begin
                        if (!i_stat.found || i_stat.fill_zero) begin
                            cmd.emit   = 1'b1;
                            cmd.status = ST_PERM;
                            cmd.msg    = 1'b1;
                            cmd.last   = 1'b1;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_HEAD;
                            n_state    = S_REL_CHK;
                        end
                    end
                    default: begin
                        if (!i_stat.found || i_stat.fill_zero) begin
                            cmd.emit    = 1'b1;
                            cmd.ans_sel = ANS_ZERO;
                            cmd.last    = 1'b1;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_HEAD;
                            n_state    = S_Q_CHK;
                        end
                    end
                endcase
            end
            S_ACQ: begin
                n_state  = S_IDLE;
                cmd.msg  = 1'b1;
                cmd.last = 1'b1;
                if (i_stat.fill_full) begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_FULL;
                end else begin
                    cmd.append = 1'b1;
                    cmd.emit   = i_stat.fill_zero;
                end
            end
            S_REL_CHK: begin
                if (i_stat.head_match) begin
                    n_state = S_SH;
                end else begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_PERM;
                    cmd.msg    = 1'b1;
                    cmd.last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_Q_CHK: begin
                cmd.emit    = 1'b1;
                cmd.ans_sel = ANS_MATCH;
                cmd.last    = 1'b1;
                n_state     = S_IDLE;
            end
            S_SH: begin
                if (i_stat.pos1_lt_fill) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS1;
                    n_state    = S_SH_WR;
                end else begin
                    cmd.dec_fill = 1'b1;
                    n_state      = S_POST;
                end
            end
            S_SH_WR: begin
                cmd.wr_shift = 1'b1;
                n_state      = S_SH;
            end
            S_POST: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_HEAD;
                if (i_stat.func == FN_RELEASE) begin
                    cmd.emit = i_stat.wake;
                    cmd.msg  = 1'b1;
                    cmd.last = i_stat.fill_zero;
                    n_state  = i_stat.fill_zero ? S_IDLE : S_GRANT;
                end else begin
                    n_state = (i_stat.fill_zero || !i_stat.pop_head) ? S_RM_DONE : S_GRANT;
                end
            end
            S_GRANT: begin
                cmd.emit   = 1'b1;
                cmd.ep_sel = EP_HEAD;
                cmd.msg    = 1'b1;
                if (i_stat.func == FN_RELEASE) begin
                    cmd.last = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_RM_DONE;
                end
            end
            S_RM_SLOT: begin
                if (i_stat.used_cur && !i_stat.fill_zero) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS;
                    n_state    = S_RM_CHK;
                end else if (i_stat.cur_last) begin
                    n_state = S_RM_DONE;
                end else begin
                    cmd.cur_next = 1'b1;
                end
            end
            S_RM_CHK: begin
                if (i_stat.head_match && (!i_stat.pos_zero || i_stat.kill)) begin
                    cmd.set_removed = 1'b1;
                    n_state         = S_SH;
                end else if (i_stat.pos1_lt_fill) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_POS1;
                    cmd.pos_inc = 1'b1;
                end else if (i_stat.cur_last) begin
                    n_state = S_RM_DONE;
                end else begin
                    cmd.cur_next = 1'b1;
                    n_state      = S_RM_SLOT;
                end
            end
            S_RM_DONE: begin
                cmd.emit    = 1'b1;
                cmd.ans_sel = ANS_REMOVED;
                cmd.last    = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/flqm_checker.sv -----
// Port-level checker for the FIFO lock queue manager, bound to the top level.
// Depends on flqm_pkg and fifo_lock_queue_manager_macros.svh.
`timescale 1ns / 1ps
`include "fifo_lock_queue_manager_macros.svh"
module flqm_checker
    import flqm_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);
    `FLQM_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, start && !busy, busy)
    `FLQM_ASSERT_NEXT(a_pair_back_to_back, i_clk, i_rst_n, o_strobe && !o_result.last, o_strobe)
    `FLQM_ASSERT_NOW(a_full_is_final_msg, i_clk, i_rst_n, o_strobe && (o_result.reply_status == ST_FULL), o_result.is_message && o_result.last)
    `FLQM_ASSERT_NOW(a_return_is_final_ok, i_clk, i_rst_n, o_strobe && !o_result.is_message, (o_result.reply_status == ST_OK) && o_result.last)
endmodule

bind fifo_lock_queue_manager flqm_checker u_flqm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ----- verif/fifo_lock_queue_manager_tb.sv -----
// Testbench for the FIFO lock queue manager: directed and random requests.
// Depends on flqm_pkg and fifo_lock_queue_manager; a lock table model predicts replies.
`timescale 1ns / 1ps
module fifo_lock_queue_manager_tb;
    import flqm_pkg::*;

    localparam int SLOTS = DEF_MUTEX_SLOTS;
    localparam int DEPTH = DEF_QUEUE_DEPTH;
    localparam int DRAIN = SLOTS * (DEPTH + 1) + 2 * DEPTH + 20;

    class lock_scoreboard;
        logic [15:0] key [SLOTS];
        bit          used [SLOTS];
        int          fill [SLOTS];
        logic [15:0] waiters [SLOTS][DEPTH];
        t_result     pending [$];
        int          errors;

        function void clear();
            for (int s = 0; s < SLOTS; s++) begin
                used[s] = 0;
                fill[s] = 0;
            end
            pending.delete();
            errors = 0;
        endfunction

        function int find_slot(logic [15:0] id);
            for (int s = 0; s < SLOTS; s++) begin
                if (used[s] && key[s] == id) return s;
            end
            return -1;
        endfunction

        function void pop_at(int s, int p);
            for (int k = p; k < fill[s] - 1; k++) waiters[s][k] = waiters[s][k + 1];
            fill[s]--;
        endfunction

        function void add(logic [15:0] ep, logic [1:0] st, logic msg, logic ans);
            t_result r;
            r.reply_endpoint = ep;
            r.reply_status = st;
            r.is_message = msg;
            r.answer = ans;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void note_item(t_item it);
            int s;
            int n0;
            bit removed;
            n0 = pending.size();
            removed = 0;
            case (it.func)
                FN_ACQUIRE: begin
                    s = find_slot(it.lock_id);
                    if (s < 0) begin
                        for (int f = 0; f < SLOTS; f++) begin
                            if (!used[f] && s < 0) s = f;
                        end
                        if (s < 0) add(it.requester, ST_FULL, 1'b1, 1'b0);
                        else begin
                            used[s] = 1;
                            key[s] = it.lock_id;
                            fill[s] = 0;
                        end
                    end
                    if (s >= 0) begin
                        if (fill[s] >= DEPTH) add(it.requester, ST_FULL, 1'b1, 1'b0);
                        else begin
                            waiters[s][fill[s]] = it.requester;
                            fill[s]++;
                            if (fill[s] == 1) add(it.requester, ST_OK, 1'b1, 1'b0);
                        end
                    end
                end
                FN_RELEASE: begin
                    s = find_slot(it.lock_id);
                    if (s < 0 || fill[s] == 0 || waiters[s][0] != it.requester)
                        add(it.requester, ST_PERM, 1'b1, 1'b0);
                    else begin
                        pop_at(s, 0);
                        if (it.wake_req) add(it.requester, ST_OK, 1'b1, 1'b0);
                        if (fill[s] != 0) add(waiters[s][0], ST_OK, 1'b1, 1'b0);
                    end
                end
                FN_REMOVE: begin
                    for (int t = 0; t < SLOTS && !removed; t++) begin
                        if (used[t]) begin
                            for (int p = 0; p < fill[t] && !removed; p++) begin
                                if (waiters[t][p] == it.requester) begin
                                    if (p != 0) begin
                                        pop_at(t, p);
                                        removed = 1;
                                    end else if (it.kill_flag) begin
                                        pop_at(t, 0);
                                        if (fill[t] != 0)
                                            add(waiters[t][0], ST_OK, 1'b1, 1'b0);
                                        removed = 1;
                                    end
                                end
                            end
                        end
                    end
                    add(it.requester, ST_OK, 1'b0, removed);
                end
                default: begin
                    s = find_slot(it.lock_id);
                    add(it.requester, ST_OK, 1'b0,
                        s >= 0 && fill[s] != 0 && waiters[s][0] == it.requester);
                end
            endcase
            if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.reply_endpoint !== want.reply_endpoint || got.reply_status !== want.reply_status
                    || got.is_message !== want.is_message || got.answer !== want.answer
                    || got.last !== want.last) begin
                $display("%0t mismatch: expected ep=%h st=%0d msg=%b ans=%b last=%b, actual ep=%h st=%0d msg=%b ans=%b last=%b",
                         $time, want.reply_endpoint, want.reply_status, want.is_message,
                         want.answer, want.last, got.reply_endpoint, got.reply_status,
                         got.is_message, got.answer, got.last);
                errors++;
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    lock_scoreboard board;
    logic [15:0] ids [8];
    logic [15:0] eps [6];

    fifo_lock_queue_manager u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_result(o_result);
    end

    // hold start until the transfer, then drop it unless another request follows at once
    task automatic send(t_item it, bit more);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        board.note_item(it);
        if (!more) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic t_item make(logic [1:0] fn, logic [15:0] id, logic [15:0] who,
                                   logic wk, logic kl);
        t_item it;
        it.func = fn;
        it.lock_id = id;
        it.requester = who;
        it.wake_req = wk;
        it.kill_flag = kl;
        return it;
    endfunction

    task automatic settle();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic t_item rand_item();
        logic [1:0] fn;
        int r;
        r = $urandom_range(0, 99);
        fn = r < 40 ? FN_ACQUIRE : r < 70 ? FN_RELEASE : r < 85 ? FN_REMOVE : FN_QUERY;
        if ($urandom_range(0, 9) == 0)
            return make(fn, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        return make(fn, ids[$urandom_range(0, 7)], eps[$urandom_range(0, 5)],
                    1'($urandom), 1'($urandom));
    endfunction

    initial begin
        int burst;
        board = new();
        board.clear();
        start   <= 1'b0;
        i_item  <= '0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(make(FN_QUERY, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1), 0);
        send(make(FN_RELEASE, 16'h0000, 16'h0000, 1'b1, 1'b0), 0);
        send(make(FN_ACQUIRE, 16'hFFFF, 16'h0001, 1'b0, 1'b0), 0);
        send(make(FN_ACQUIRE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0), 1);
        send(make(FN_ACQUIRE, 16'hFFFF, 16'h0001, 1'b0, 1'b0), 0);
        send(make(FN_RELEASE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0), 0);
        send(make(FN_QUERY, 16'hFFFF, 16'h0001, 1'b0, 1'b0), 0);
        send(make(FN_REMOVE, 16'h0000, 16'hFFFF, 1'b0, 1'b0), 0);
        send(make(FN_REMOVE, 16'h0000, 16'h0001, 1'b0, 1'b0), 0);
        send(make(FN_REMOVE, 16'h0000, 16'h0001, 1'b0, 1'b1), 0);
        send(make(FN_RELEASE, 16'hFFFF, 16'h0001, 1'b1, 1'b0), 0);
        send(make(FN_RELEASE, 16'hFFFF, 16'h0001, 1'b0, 1'b0), 0);
        // fill one queue past its depth
        for (int k = 0; k <= DEPTH; k++)
            send(make(FN_ACQUIRE, 16'h1234, 16'(k), 1'b0, 1'b0), 1);
        // fill the slot table past its size
        for (int k = 0; k < SLOTS; k++)
            send(make(FN_ACQUIRE, 16'(16'h2000 + k), 16'hAAAA, 1'b0, 1'b0), 1);
        start <= 1'b0;
        settle();

        // reuse the taken ids so random requests hit real queues
        for (int k = 0; k < 8; k++) ids[k] = k == 0 ? 16'hFFFF : k == 1 ? 16'h1234
                                              : 16'(16'h2000 + k);
        for (int k = 0; k < 6; k++) eps[k] = k == 5 ? 16'hAAAA : 16'(k);
        for (int n = 0; n < 750; n += burst) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) send(rand_item(), k != burst - 1);
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (n % 200 == 0) while (board.pending.size() != 0) @(posedge i_clk);
        end
        settle();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/flqm_pkg.sv
rtl/flqm_dp.sv
rtl/flqm_ctrl.sv
rtl/fifo_lock_queue_manager.sv
rtl/flqm_checker.sv
verif/fifo_lock_queue_manager_tb.sv
